// ===== rtl/core/factorial_divisor_count_mod_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the factorial divisor count block
// Short forms for same-cycle and next-cycle implications on clk / arst_n.
// ----------------------------------------------------------------------------
`ifndef FACTORIAL_DIVISOR_COUNT_MOD_ASSERT_SVH
`define FACTORIAL_DIVISOR_COUNT_MOD_ASSERT_SVH

// antecedent and consequent in the same cycle
`define FDCM_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("fdcm same-cycle check failed");

// consequent in the cycle after the antecedent
`define FDCM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("fdcm next-cycle check failed");

`endif

// ===== rtl/core/fdcm_pkg.sv =====
// ----------------------------------------------------------------------------
// fdcm_pkg
// Shared types, constants and the microcode table of the divisor count block.
// ----------------------------------------------------------------------------
`default_nettype none

package fdcm_pkg;

	localparam int unsigned NUM_W = 11;
	localparam int unsigned RES_W = 30;
	localparam int unsigned PC_W  = 4;

	localparam logic [RES_W-1:0] DIV_MODULUS = 30'd1000000007;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_CLEAR,
		OP_PINIT,
		OP_READ,
		OP_SEED,
		OP_WALK,
		OP_POW,
		OP_RESEED,
		OP_FIN,
		OP_TAKE,
		OP_PINC,
		OP_EMIT
	} op_t;

	typedef enum logic [3:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_START,
		C_M_LT_N,
		C_P_GT_N,
		C_FLAG,
		C_M_GT_N,
		C_Q_LE_N,
		C_MUL_BUSY
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ctl_t;

	typedef struct packed {
		logic start;
		logic m_lt_n;
		logic p_gt_n;
		logic flag;
		logic m_gt_n;
		logic q_le_n;
		logic mul_busy;
	} stat_t;

	// step addresses
	localparam logic [PC_W-1:0] A_IDLE   = 4'd0;
	localparam logic [PC_W-1:0] A_CLEAR  = 4'd1;
	localparam logic [PC_W-1:0] A_PINIT  = 4'd2;
	localparam logic [PC_W-1:0] A_PLOOP  = 4'd3;
	localparam logic [PC_W-1:0] A_SEED   = 4'd4;
	localparam logic [PC_W-1:0] A_WALK   = 4'd5;
	localparam logic [PC_W-1:0] A_STEP   = 4'd6;
	localparam logic [PC_W-1:0] A_POW    = 4'd7;
	localparam logic [PC_W-1:0] A_RESEED = 4'd8;
	localparam logic [PC_W-1:0] A_FIN    = 4'd9;
	localparam logic [PC_W-1:0] A_WAIT   = 4'd10;
	localparam logic [PC_W-1:0] A_TAKE   = 4'd11;
	localparam logic [PC_W-1:0] A_PINC   = 4'd12;
	localparam logic [PC_W-1:0] A_EMIT   = 4'd13;

	// Program: clear histogram, then for each unmarked p walk the multiples of
	// every power p^k <= n (marking composites on the first pass), fold the
	// exponent plus one into the running product.
	function automatic ctl_t ucode_word(input logic [PC_W-1:0] pc);
		ctl_t w;
		unique case (pc)
			A_IDLE:   w = '{op: OP_IDLE,   cond: C_NO_START, target: A_IDLE};
			A_CLEAR:  w = '{op: OP_CLEAR,  cond: C_M_LT_N,   target: A_CLEAR};
			A_PINIT:  w = '{op: OP_PINIT,  cond: C_NEVER,    target: A_IDLE};
			A_PLOOP:  w = '{op: OP_READ,   cond: C_P_GT_N,   target: A_EMIT};
			A_SEED:   w = '{op: OP_SEED,   cond: C_FLAG,     target: A_PINC};
			A_WALK:   w = '{op: OP_NOP,    cond: C_M_GT_N,   target: A_POW};
			A_STEP:   w = '{op: OP_WALK,   cond: C_ALWAYS,   target: A_WALK};
			A_POW:    w = '{op: OP_POW,    cond: C_NEVER,    target: A_IDLE};
			A_RESEED: w = '{op: OP_RESEED, cond: C_Q_LE_N,   target: A_WALK};
			A_FIN:    w = '{op: OP_FIN,    cond: C_NEVER,    target: A_IDLE};
			A_WAIT:   w = '{op: OP_NOP,    cond: C_MUL_BUSY, target: A_WAIT};
			A_TAKE:   w = '{op: OP_TAKE,   cond: C_NEVER,    target: A_IDLE};
			A_PINC:   w = '{op: OP_PINC,   cond: C_ALWAYS,   target: A_PLOOP};
			A_EMIT:   w = '{op: OP_EMIT,   cond: C_ALWAYS,   target: A_IDLE};
			default:  w = '{op: OP_NOP,    cond: C_ALWAYS,   target: A_IDLE};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fdcm_mulmod.sv =====
// ----------------------------------------------------------------------------
// fdcm_mulmod
// Iterative modular multiplier: a * b mod DIV_MODULUS, one bit of b per double
// state then conditional add state, MSB first; start is taken only when idle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcm_mulmod import fdcm_pkg::*; #(
	parameter int unsigned B_WIDTH = 11
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [RES_W-1:0]   a,
	input  wire logic [B_WIDTH-1:0] b,
	output logic                    busy,
	output logic [RES_W-1:0]        result
);

	localparam int unsigned IW = (B_WIDTH > 1) ? $clog2(B_WIDTH) : 1;

	typedef enum logic [1:0] {
		MM_IDLE,
		MM_DBL,
		MM_ADD
	} mm_state_t;

	mm_state_t          state_q;
	logic [IW-1:0]      idx_q;
	logic [RES_W-1:0]   acc_q;
	logic [RES_W-1:0]   a_q;
	logic [B_WIDTH-1:0] b_q;

	logic [RES_W:0]     dbl_raw;
	logic [RES_W:0]     add_raw;
	logic [RES_W-1:0]   dbl_red;
	logic [RES_W-1:0]   add_red;

	always_comb begin
		dbl_raw = {acc_q, 1'b0};
		add_raw = {1'b0, acc_q} + {1'b0, a_q};
		dbl_red = (dbl_raw >= {1'b0, DIV_MODULUS}) ?
			RES_W'(dbl_raw - {1'b0, DIV_MODULUS}) : RES_W'(dbl_raw);
		add_red = (add_raw >= {1'b0, DIV_MODULUS}) ?
			RES_W'(add_raw - {1'b0, DIV_MODULUS}) : RES_W'(add_raw);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= MM_IDLE;
			idx_q   <= '0;
			acc_q   <= '0;
			a_q     <= '0;
			b_q     <= '0;
		end else begin
			unique case (state_q)
				MM_IDLE: begin
					if (start) begin
						a_q     <= a;
						b_q     <= b;
						acc_q   <= '0;
						idx_q   <= IW'(B_WIDTH - 1);
						state_q <= MM_DBL;
					end
				end
				MM_DBL: begin
					acc_q   <= dbl_red;
					state_q <= MM_ADD;
				end
				MM_ADD: begin
					if (b_q[idx_q]) begin
						acc_q <= add_red;
					end
					if (idx_q == '0) begin
						state_q <= MM_IDLE;
					end else begin
						idx_q   <= idx_q - IW'(1);
						state_q <= MM_DBL;
					end
				end
				default: state_q <= MM_IDLE;
			endcase
		end
	end

	assign busy   = (state_q != MM_IDLE);
	assign result = acc_q;

endmodule

`default_nettype wire

// ===== rtl/core/fdcm_seq.sv =====
// ----------------------------------------------------------------------------
// fdcm_seq
// Microcode sequencer: step counter, control word lookup, conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcm_seq import fdcm_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire stat_t stat,
	output ctl_t       ctl
);

	logic [PC_W-1:0] pc_q;
	logic            take;

	assign ctl = ucode_word(pc_q);

	always_comb begin
		unique case (ctl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_START: take = !stat.start;
			C_M_LT_N:   take = stat.m_lt_n;
			C_P_GT_N:   take = stat.p_gt_n;
			C_FLAG:     take = stat.flag;
			C_M_GT_N:   take = stat.m_gt_n;
			C_Q_LE_N:   take = stat.q_le_n;
			C_MUL_BUSY: take = stat.mul_busy;
			default:    take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= A_IDLE;
		end else begin
			pc_q <= take ? ctl.target : pc_q + PC_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/fdcm_datapath.sv =====
// ----------------------------------------------------------------------------
// fdcm_datapath
// Counters, exponent histogram memory, power multiplier and modular product
// register, driven one control word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fdcm_datapath import fdcm_pkg::*; #(
	parameter int unsigned MAX_N = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ctl_t             ctl,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] number,
	output stat_t                 stat,
	output logic [RES_W-1:0]      divisor_count,
	output logic                  done
);

	localparam int unsigned W  = $clog2(MAX_N + 1);
	localparam int unsigned CW = W + 1;
	localparam int unsigned QW = 2 * W;

	// histogram word: {composite mark, exponent}
	logic [W:0]       mem_q [0:MAX_N];
	logic [W:0]       rd_q;

	logic [W-1:0]     n_q;
	logic [CW-1:0]    p_q;
	logic [CW-1:0]    m_q;
	logic [QW-1:0]    q_q;
	logic [W-1:0]     e_q;
	logic [RES_W-1:0] prod_q;
	logic [RES_W-1:0] count_q;
	logic             done_q;

	logic [W-1:0]     n_sat;
	logic             rd_en;
	logic             wr_en;
	logic [W-1:0]     wr_addr;
	logic [W:0]       wr_data;
	logic             first_pass;
	logic             mul_busy;
	logic [RES_W-1:0] mul_result;

	assign n_sat = (32'(number) > 32'(MAX_N)) ? W'(MAX_N) : W'(number);
	assign first_pass = (q_q == QW'(p_q));

	always_comb begin
		stat.start    = start;
		stat.m_lt_n   = (m_q < CW'(n_q));
		stat.p_gt_n   = (p_q > CW'(n_q));
		stat.flag     = rd_q[W];
		stat.m_gt_n   = (m_q > CW'(n_q));
		stat.q_le_n   = (q_q <= QW'(n_q));
		stat.mul_busy = mul_busy;
	end

	always_comb begin
		rd_en   = (ctl.op == OP_READ) && !stat.p_gt_n;
		wr_en   = 1'b0;
		wr_addr = m_q[W-1:0];
		wr_data = '0;
		case (ctl.op)
			OP_CLEAR: wr_en = 1'b1;
			OP_WALK: begin
				// mark composites only while walking multiples of p itself
				wr_en   = first_pass && (m_q != p_q);
				wr_data = {1'b1, {W{1'b0}}};
			end
			OP_FIN: begin
				wr_en   = 1'b1;
				wr_addr = p_q[W-1:0];
				wr_data = {1'b0, e_q};
			end
			default: wr_en = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem_q[p_q[W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			OP_IDLE: begin
				m_q    <= '0;
				prod_q <= RES_W'(1);
				if (start) begin
					n_q <= n_sat;
				end
			end
			OP_CLEAR:  m_q <= m_q + CW'(1);
			OP_PINIT:  p_q <= CW'(2);
			OP_SEED: begin
				q_q <= QW'(p_q);
				m_q <= p_q;
				e_q <= '0;
			end
			OP_WALK: begin
				e_q <= e_q + W'(1);
				m_q <= m_q + q_q[CW-1:0];
			end
			OP_POW:    q_q <= QW'(q_q[W-1:0]) * QW'(p_q[W-1:0]);
			OP_RESEED: m_q <= q_q[CW-1:0];
			OP_TAKE:   prod_q <= mul_result;
			OP_PINC:   p_q <= p_q + CW'(1);
			OP_EMIT:   count_q <= prod_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (ctl.op == OP_EMIT);
		end
	end

	fdcm_mulmod #(
		.B_WIDTH (W)
	) u_mulmod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.op == OP_FIN),
		.a      (prod_q),
		.b      (e_q + W'(1)),
		.busy   (mul_busy),
		.result (mul_result)
	);

	assign divisor_count = count_q;
	assign done          = done_q;

endmodule

`default_nettype wire

// ===== rtl/core/factorial_divisor_count_mod.sv =====
// One request at a time; busy stays high until the done cycle while the
// microcode loops over candidates and waits on the bit-serial modular multiplier.
// Reset clears the step counter, multiplier state and done; the histogram is
// cleared by each request itself.
// ----------------------------------------------------------------------------
// factorial_divisor_count_mod
// Number of divisors of n! modulo 1000000007, microcode-sequenced.
// ----------------------------------------------------------------------------
`default_nettype none

`include "factorial_divisor_count_mod_assert.svh"

module factorial_divisor_count_mod import fdcm_pkg::*; #(
	parameter int unsigned MAX_N = 1024
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] number,
	output logic                  busy,
	output logic [RES_W-1:0]      divisor_count,
	output logic                  done
);

	ctl_t  ctl;
	stat_t stat;

	fdcm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctl    (ctl)
	);

	fdcm_datapath #(
		.MAX_N (MAX_N)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.start         (start),
		.number        (number),
		.stat          (stat),
		.divisor_count (divisor_count),
		.done          (done)
	);

	assign busy = (ctl.op != OP_IDLE);

	`FDCM_ASSERT_NEXT(a_accept_clears, (start && !busy), (ctl.op == OP_CLEAR))
	`FDCM_ASSERT_NOW(a_result_range, done, (divisor_count < DIV_MODULUS))
	`FDCM_ASSERT_NEXT(a_done_single, done, !done)
	`FDCM_ASSERT_NOW(a_idle_mul_quiet, (ctl.op == OP_IDLE), !stat.mul_busy)

endmodule

`default_nettype wire

// ===== sim/factorial_divisor_count_mod_test.sv =====
// ----------------------------------------------------------------------------
// factorial_divisor_count_mod_test
// Drives numbers into the divisor count block and checks every divisor_count
// against the divisor count of n! modulo 1000000007, worked out from the
// prime exponents of n!. Directed edge values come first, then random requests
// in phases with and without sender idling.
// ----------------------------------------------------------------------------
`default_nettype none

module factorial_divisor_count_mod_test import fdcm_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MAX_N         = 1024;
	localparam int unsigned RANDOM_COUNT  = 80;
	localparam longint unsigned CYCLE_LIMIT = 64'd6_000_000;
	localparam int unsigned TAIL_CYCLES   = 200;

	typedef struct {
		logic [NUM_W-1:0] value;
		int unsigned      idle_pct;
		bit               drain;
	} request_t;

	logic             clk;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic [NUM_W-1:0] number = '0;
	logic             busy;
	logic [RES_W-1:0] divisor_count;
	logic             done;

	request_t         pending_requests[$];
	logic [RES_W-1:0] expected_counts[$];
	bit               request_taken = 1'b0;
	int unsigned      mismatch_count = 0;
	int unsigned      accepted_count = 0;
	int unsigned      result_count = 0;
	longint unsigned  cycle_count = 0;

	factorial_divisor_count_mod #(.MAX_N(MAX_N)) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.number       (number),
		.busy         (busy),
		.divisor_count(divisor_count),
		.done         (done)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// d(n!) = product over primes p <= n of (e_p + 1), e_p by Legendre's formula
	function automatic logic [RES_W-1:0] divisors_of_factorial(input logic [NUM_W-1:0] n_in);
		int unsigned     n;
		int unsigned     p;
		int unsigned     m;
		int unsigned     q;
		int unsigned     e;
		longint unsigned prod;
		bit              composite [0:MAX_N];
		n = (n_in > MAX_N) ? MAX_N : int'(n_in);
		prod = 1;
		for (p = 0; p <= MAX_N; p++)
			composite[p] = 1'b0;
		for (p = 2; p <= n; p++) begin
			if (!composite[p]) begin
				for (m = p * p; m <= n; m += p)
					composite[m] = 1'b1;
				e = 0;
				q = n;
				while (q >= p) begin
					q = q / p;
					e += q;
				end
				prod = (prod * (e + 1)) % longint'(DIV_MODULUS);
			end
		end
		return RES_W'(prod);
	endfunction

	// driver: change inputs on the falling edge, hold start until the request is taken
	always @(negedge clk) begin : drive
		logic             next_start;
		logic [NUM_W-1:0] next_number;
		request_t         head;
		next_start = start;
		next_number = number;
		if (!arst_n) begin
			next_start = 1'b0;
		end else if (!start || request_taken) begin
			next_start = 1'b0;
			next_number = NUM_W'($urandom);
			if (pending_requests.size() != 0) begin
				if (pending_requests[0].drain && expected_counts.size() != 0) begin
					next_start = 1'b0;
				end else if ($urandom_range(99, 0) < pending_requests[0].idle_pct) begin
					next_start = 1'b0;
				end else begin
					head = pending_requests.pop_front();
					next_start = 1'b1;
					next_number = head.value;
				end
			end
		end
		start <= next_start;
		number <= next_number;
	end

	// monitor: check results and predict each accepted request on the rising edge
	always @(posedge clk) begin : watch
		logic [RES_W-1:0] want;
		if (!arst_n) begin
			request_taken = 1'b0;
		end else begin
			if (done) begin
				result_count++;
				if (expected_counts.size() == 0) begin
					$error("divisor_count: unexpected result, actual %0d", divisor_count);
					mismatch_count++;
				end else begin
					want = expected_counts.pop_front();
					if (divisor_count !== want) begin
						$error("divisor_count: expected %0d, actual %0d", want, divisor_count);
						mismatch_count++;
					end
				end
			end
			request_taken = start && !busy;
			if (request_taken) begin
				expected_counts.push_back(divisors_of_factorial(number));
				accepted_count++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_counts.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		logic [NUM_W-1:0] edge_values [$];
		request_t         req;
		int unsigned      phase;
		int unsigned      pick;
		int unsigned      large_count;
		int unsigned      drain_count;
		edge_values = {11'd0, 11'd1, 11'd2, 11'd3, 11'd4, 11'd5, 11'd6, 11'd7, 11'd8,
			11'd16, 11'd31, 11'd97, 11'd100, 11'd128, 11'd255, 11'd512,
			11'd1023, 11'd1024, 11'd1025, 11'd1536, 11'd2047};
		large_count = 0;
		drain_count = 0;
		foreach (edge_values[i]) begin
			req.value = edge_values[i];
			req.idle_pct = 0;
			// wait out the previous request before the maximum size
			req.drain = (edge_values[i] == 11'd1024);
			pending_requests.push_back(req);
		end
		for (int i = 0; i < RANDOM_COUNT; i++) begin
			phase = (i * 4) / RANDOM_COUNT;
			pick = $urandom_range(99, 0);
			// keep most requests small, the factoring pass grows with n
			if (pick < 8)
				req.value = NUM_W'($urandom_range(2047, 700));
			else if (pick < 20)
				req.value = NUM_W'($urandom_range(699, 151));
			else
				req.value = NUM_W'($urandom_range(150, 0));
			case (phase)
				0: req.idle_pct = 0;
				1: req.idle_pct = 70;
				2: req.idle_pct = 0;
				default: req.idle_pct = 31;
			endcase
			req.drain = ((i * 4) % RANDOM_COUNT == 0) || ($urandom_range(99, 0) < 5);
			pending_requests.push_back(req);
		end
		foreach (pending_requests[i]) begin
			if (pending_requests[i].value >= 700)
				large_count++;
			if (pending_requests[i].drain)
				drain_count++;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		while (pending_requests.size() != 0 || start || expected_counts.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("covered %0d requests, %0d of them with n of 700 or more, %0d results",
			accepted_count, large_count, result_count);
		$display("sender idling at 0, 70 and 31 percent, %0d pauses to drain, %0d mismatches",
			drain_count, mismatch_count);
		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

`default_nettype wire
